// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/ltq_pkg.sv =====
// Types, codes and the luma function of the luma tone quantizer.
package ltq_pkg;

  localparam int PixW = 8;
  localparam int CntW = 3;

  localparam logic [PixW-1:0] LumaMinInit = 8'd255;
  localparam logic [PixW-1:0] LumaMaxInit = 8'd0;
  localparam logic [PixW-1:0] ToneInit    = 8'd1;
  localparam logic [PixW-1:0] BinInit     = 8'd1;
  localparam logic [PixW-1:0] SatMax      = 8'd255;

  localparam logic OpStats = 1'b0;
  localparam logic OpQuant = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_BIN,
    S_QUANT,
    S_EMIT
  } state_t;

  // Q8 BT.601 weights, truncated
  function automatic logic [PixW-1:0] luma_of(input logic [PixW-1:0] r,
                                               input logic [PixW-1:0] g,
                                               input logic [PixW-1:0] b);
    logic [15:0] sum;
    sum = 16'(r) * 16'd77 + 16'(g) * 16'd150 + 16'(b) * 16'd29;
    return sum[15:8];
  endfunction

endpackage

// ===== hw/rtl/luma_tone_quantizer.sv =====
// Luma tone quantizer: RGB to luma, frame range statistics, uniform quantization.
`include "assert_macros.svh"

// Each pixel is converted to luma (77R+150G+29B)>>8. Opcode 0 pixels return luma and
// update the frame's luma range (first_pixel restarts it). Opcode 1 pixels return
// quantized luma, or plain luma while no usable bin width is set, through
// one radix-2 divider that makes one quotient bit per cycle: a plain quantize pixel
// takes 8 divider steps, and the first pixel of a quantize pass first divides the
// range by tone_count to get the bin width. One pixel is in work at a time; a finished
// result waits in the output register.
module luma_tone_quantizer
  import ltq_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  // configuration write channel
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [PixW-1:0] tone_count,
  // pixel input channel
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            opcode,
  input  logic            first_pixel,
  input  logic [PixW-1:0] red,
  input  logic [PixW-1:0] green,
  input  logic [PixW-1:0] blue,
  // result channel
  output logic            out_valid,
  input  logic            out_stall,
  output logic [PixW-1:0] gray_out,
  output logic            quantized,
  output logic [PixW-1:0] range_low,
  output logic [PixW-1:0] range_high
);

  state_t state, state_next;

  logic [PixW-1:0] tone_reg;
  logic            op_r;
  logic            first_r;
  logic [PixW-1:0] luma_r;
  logic [PixW-1:0] luma_min;
  logic [PixW-1:0] luma_max;
  logic [PixW-1:0] bin_width;
  logic            quantize_active;

  logic [PixW-1:0] div_rem;
  logic [PixW-1:0] div_quo;
  logic [PixW-1:0] div_divisor;
  logic [CntW-1:0] div_count;

  logic [PixW-1:0] gray_pend;
  logic            quant_pend;

  logic            in_xfer;
  logic            emit_load;
  logic            div_last;

  // range and bin decision for the first quantize pixel
  logic [PixW-1:0] range_w;
  logic            bin_ok;
  logic            quant_go;

  // divider step
  logic [PixW:0]   div_shift;
  logic            div_ge;
  logic [PixW:0]   div_diff;
  logic [PixW-1:0] rem_next;
  logic [PixW-1:0] quo_next;

  // statistics update
  logic [PixW-1:0] min_base;
  logic [PixW-1:0] max_base;

  // quantized value, one bit of headroom for saturation
  logic [PixW:0]   quant_sum;

  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && !in_stall;
  assign div_last  = (div_count == '0);

  assign range_w  = (luma_max >= luma_min) ? (luma_max - luma_min) : '0;
  assign bin_ok   = (tone_reg != '0) && (tone_reg <= range_w);
  assign quant_go = quantize_active && (bin_width != '0);

  assign div_shift = {div_rem, div_quo[PixW-1]};
  assign div_ge    = (div_shift >= {1'b0, div_divisor});
  assign div_diff  = div_shift - {1'b0, div_divisor};
  assign rem_next  = div_ge ? div_diff[PixW-1:0] : div_shift[PixW-1:0];
  assign quo_next  = {div_quo[PixW-2:0], div_ge};

  assign min_base = first_r ? LumaMinInit : luma_min;
  assign max_base = first_r ? LumaMaxInit : luma_max;

  assign quant_sum = {1'b0, luma_r} - {1'b0, rem_next} + {2'b00, div_divisor[PixW-1:1]};

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_START;
      end
      S_START: begin
        if (op_r == OpStats) begin
          state_next = S_EMIT;
        end else if (first_r) begin
          state_next = bin_ok ? S_BIN : S_EMIT;
        end else begin
          state_next = quant_go ? S_QUANT : S_EMIT;
        end
      end
      S_BIN: begin
        if (div_last) state_next = S_QUANT;
      end
      S_QUANT: begin
        if (div_last) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || !out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall  = 1'b1;
    emit_load = 1'b0;
    unique case (state)
      S_IDLE:  in_stall = 1'b0;
      S_EMIT:  emit_load = !out_valid || !out_stall;
      S_START, S_BIN, S_QUANT: begin
        in_stall  = 1'b1;
        emit_load = 1'b0;
      end
      default: in_stall = 1'b1;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      tone_reg        <= ToneInit;
      luma_min        <= LumaMinInit;
      luma_max        <= LumaMaxInit;
      bin_width       <= BinInit;
      quantize_active <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) tone_reg <= tone_count;
      // fold luma into the frame range
      if (state == S_START && op_r == OpStats) begin
        luma_min <= (luma_r < min_base) ? luma_r : min_base;
        luma_max <= (luma_r > max_base) ? luma_r : max_base;
      end
      // latch pass-through on an unusable range
      if (state == S_START && op_r == OpQuant && first_r && !bin_ok) begin
        quantize_active <= 1'b0;
      end
      // latch the bin width when its division ends
      if (state == S_BIN && div_last) begin
        bin_width       <= quo_next;
        quantize_active <= 1'b1;
      end
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath: capture pixel, run divider, hold result
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r    <= opcode;
      first_r <= first_pixel;
      luma_r  <= luma_of(red, green, blue);
    end
    if (state == S_START) begin
      gray_pend  <= luma_r;
      quant_pend <= 1'b0;
      div_rem    <= '0;
      div_count  <= CntW'(PixW - 1);
      if (first_r) begin
        div_quo     <= range_w;
        div_divisor <= tone_reg;
      end else begin
        div_quo     <= luma_r;
        div_divisor <= bin_width;
      end
    end
    // restart the divider on the pixel luma with the new bin width
    if (state == S_BIN && div_last) begin
      div_rem     <= '0;
      div_quo     <= luma_r;
      div_divisor <= quo_next;
      div_count   <= CntW'(PixW - 1);
    end else if (state == S_BIN || state == S_QUANT) begin
      div_rem   <= rem_next;
      div_quo   <= quo_next;
      div_count <= div_count - 1'b1;
    end
    // luma minus remainder is the bin floor; add half a bin and saturate
    if (state == S_QUANT && div_last) begin
      gray_pend  <= quant_sum[PixW] ? SatMax : quant_sum[PixW-1:0];
      quant_pend <= 1'b1;
    end
    if (emit_load) begin
      gray_out   <= gray_pend;
      quantized  <= quant_pend;
      range_low  <= luma_min;
      range_high <= luma_max;
    end
  end

  `ASSERT_IMPLY(a_bin_nonzero, quantize_active, bin_width != '0)
  `ASSERT_IMPLY(a_div_nonzero, state == S_QUANT, div_divisor != '0)
  `ASSERT_IMPLY(a_range_order, state == S_EMIT && op_r == OpStats, luma_min <= luma_max)
  `ASSERT_NEXT(a_bin_to_quant, state == S_BIN && div_last, state == S_QUANT && quantize_active)

endmodule
